// File: hw/rtl/tpps_pkg.sv
// tpps_pkg: constants, configuration codes and shared types of the touchpad packet scaler.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tpps_pkg;

    localparam int MAX_FINGERS = 16;
    localparam int X_SPAN      = 1280;
    localparam int Y_SPAN      = 800;
    localparam int FORCE_SPAN  = 256;
    localparam int WIDTH_SPAN  = 16;

    localparam int HDR_LEN = 26;
    localparam int REC_LEN = 28;
    localparam int MAX_LEN = HDR_LEN + REC_LEN * MAX_FINGERS;

    localparam int BW = $clog2(MAX_LEN + 1);
    localparam int PW = $clog2(REC_LEN);
    localparam int FW = $clog2(MAX_FINGERS + 1);

    localparam int SPAN_XY   = (X_SPAN > Y_SPAN) ? X_SPAN : Y_SPAN;
    localparam int SPAN_FW   = (FORCE_SPAN > WIDTH_SPAN) ? FORCE_SPAN : WIDTH_SPAN;
    localparam int SPAN_MAX  = (SPAN_XY > SPAN_FW) ? SPAN_XY : SPAN_FW;
    localparam int QW        = ($clog2(SPAN_MAX) > 2) ? $clog2(SPAN_MAX) : 2;
    localparam int SW        = $clog2(SPAN_MAX + 1);
    localparam int MW        = 17;

    localparam int CW  = 16;
    localparam int CIW = 3;
    localparam int QD  = 2;

    localparam logic [CIW-1:0] CFG_X_MIN       = 3'd0;
    localparam logic [CIW-1:0] CFG_X_MAX       = 3'd1;
    localparam logic [CIW-1:0] CFG_Y_MIN       = 3'd2;
    localparam logic [CIW-1:0] CFG_Y_MAX       = 3'd3;
    localparam logic [CIW-1:0] CFG_FORCE_RANGE = 3'd4;
    localparam logic [CIW-1:0] CFG_SIZE_RANGE  = 3'd5;

    localparam logic [CW-1:0] X_MIN_RST       = 16'(-4824);
    localparam logic [CW-1:0] X_MAX_RST       = 16'(5342);
    localparam logic [CW-1:0] Y_MIN_RST       = 16'(-172);
    localparam logic [CW-1:0] Y_MAX_RST       = 16'(5820);
    localparam logic [CW-1:0] FORCE_RANGE_RST = 16'(256);
    localparam logic [CW-1:0] SIZE_RANGE_RST  = 16'(2048);

    typedef struct packed {
        logic [CW-1:0] x_min;
        logic [CW-1:0] x_max;
        logic [CW-1:0] y_min;
        logic [CW-1:0] y_max;
        logic [CW-1:0] force_range;
        logic [CW-1:0] size_range;
    } t_cfg;

    typedef struct packed {
        logic          bad;
        logic [FW-1:0] fingers;
        logic [15:0]   raw_force;
        logic [15:0]   raw_size;
        logic [15:0]   raw_x;
        logic [15:0]   raw_y;
    } t_pkt;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// File: hw/rtl/tpps_front.sv
// tpps_front: byte parser; tracks report length and record phase, captures finger 0 words.
// Depends on tpps_pkg; queues a summary at every report end but the first after reset.
`timescale 1ns / 1ps

module tpps_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  logic [7:0]       i_data_byte,
    input  logic             i_last_byte,
    output logic             o_push,
    output tpps_pkg::t_pkt   o_pkt
);
    import tpps_pkg::*;

    logic [BW-1:0] r_byte_index, n_byte_index;
    logic [PW-1:0] r_phase, n_phase;
    logic [FW-1:0] r_fingers, n_fingers;
    logic          r_ovf, n_ovf;
    logic          r_seen, n_seen;
    logic [15:0]   r_raw_force, n_raw_force;
    logic [15:0]   r_raw_size, n_raw_size;
    logic [15:0]   r_raw_x, n_raw_x;
    logic [15:0]   r_raw_y, n_raw_y;

    always_comb begin
        n_byte_index = r_byte_index;
        n_phase      = r_phase;
        n_fingers    = r_fingers;
        n_ovf        = r_ovf;
        n_seen       = r_seen;
        n_raw_force  = r_raw_force;
        n_raw_size   = r_raw_size;
        n_raw_x      = r_raw_x;
        n_raw_y      = r_raw_y;
        o_push       = 1'b0;
        o_pkt        = '0;
        if (i_take) begin
            if (!r_ovf) begin
                case (r_byte_index)
                    BW'(HDR_LEN + 2):  n_raw_x[7:0]      = i_data_byte;
                    BW'(HDR_LEN + 3):  n_raw_x[15:8]     = i_data_byte;
                    BW'(HDR_LEN + 4):  n_raw_y[7:0]      = i_data_byte;
                    BW'(HDR_LEN + 5):  n_raw_y[15:8]     = i_data_byte;
                    BW'(HDR_LEN + 10): n_raw_size[7:0]   = i_data_byte;
                    BW'(HDR_LEN + 11): n_raw_size[15:8]  = i_data_byte;
                    BW'(HDR_LEN + 16): n_raw_force[7:0]  = i_data_byte;
                    BW'(HDR_LEN + 17): n_raw_force[15:8] = i_data_byte;
                    default: ;
                endcase
                if (r_byte_index >= BW'(MAX_LEN)) begin
                    n_ovf = 1'b1;
                end else begin
                    n_byte_index = r_byte_index + 1'b1;
                    if (r_byte_index >= BW'(HDR_LEN)) begin
                        if (r_phase == PW'(REC_LEN - 1)) begin
                            n_phase   = '0;
                            n_fingers = r_fingers + 1'b1;
                        end else begin
                            n_phase = r_phase + 1'b1;
                        end
                    end
                end
            end
            if (i_last_byte) begin
                o_push          = r_seen;
                o_pkt.bad       = n_ovf || (n_byte_index < BW'(HDR_LEN)) || (n_phase != '0);
                o_pkt.fingers   = n_fingers;
                o_pkt.raw_force = n_raw_force;
                o_pkt.raw_size  = n_raw_size;
                o_pkt.raw_x     = n_raw_x;
                o_pkt.raw_y     = n_raw_y;
                n_seen          = 1'b1;
                n_byte_index    = '0;
                n_phase         = '0;
                n_fingers       = '0;
                n_ovf           = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index <= '0;
            r_phase      <= '0;
            r_fingers    <= '0;
            r_ovf        <= 1'b0;
            r_seen       <= 1'b0;
            r_raw_force  <= '0;
            r_raw_size   <= '0;
            r_raw_x      <= '0;
            r_raw_y      <= '0;
        end else begin
            r_byte_index <= n_byte_index;
            r_phase      <= n_phase;
            r_fingers    <= n_fingers;
            r_ovf        <= n_ovf;
            r_seen       <= n_seen;
            r_raw_force  <= n_raw_force;
            r_raw_size   <= n_raw_size;
            r_raw_x      <= n_raw_x;
            r_raw_y      <= n_raw_y;
        end
    end

endmodule

// File: hw/rtl/tpps_fifo.sv
// tpps_fifo: short queue of report summaries between parser and scaling back end.
// Depends on tpps_pkg for the entry type and depth.
`timescale 1ns / 1ps

module tpps_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tpps_pkg::t_pkt    i_pkt,
    input  logic              i_pop,
    output tpps_pkg::t_pkt    o_head,
    output tpps_pkg::t_q_stat o_stat
);
    import tpps_pkg::*;

    localparam int QAW = (QD > 1) ? $clog2(QD) : 1;
    localparam int QCW = $clog2(QD + 1);

    t_pkt           r_mem [QD];
    logic [QAW-1:0] r_wr, n_wr;
    logic [QAW-1:0] r_rd, n_rd;
    logic [QCW-1:0] r_count, n_count;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == QAW'(QD - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == QAW'(QD - 1)) ? '0 : r_rd + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
        if (i_push) begin
            r_mem[r_wr] <= i_pkt;
        end
    end

    assign o_head       = r_mem[r_rd];
    assign o_stat.full  = (r_count == QCW'(QD));
    assign o_stat.empty = (r_count == '0);

endmodule

// File: hw/rtl/tpps_back.sv
// tpps_back: scaling back end; four clamped scalings through one shared restoring divider.
// Depends on tpps_pkg; drains the report queue and holds the registered result item.
`timescale 1ns / 1ps

module tpps_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tpps_pkg::t_cfg    i_cfg,
    input  tpps_pkg::t_q_stat i_q_stat,
    input  tpps_pkg::t_pkt    i_head,
    output logic              o_pop,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic              o_status,
    output logic [4:0]        o_finger_count,
    output logic              o_touch_valid,
    output logic [7:0]        o_pressure,
    output logic [3:0]        o_tool_width,
    output logic [10:0]       o_x_pos,
    output logic [9:0]        o_y_pos,
    output logic [1:0]        o_tool_class
);
    import tpps_pkg::*;

    localparam int NJOB = 4;
    localparam int JW   = $clog2(NJOB);
    localparam int CNTW = $clog2(QW);

    localparam logic [JW-1:0] JOB_FORCE = 2'd0;
    localparam logic [JW-1:0] JOB_SIZE  = 2'd1;
    localparam logic [JW-1:0] JOB_X     = 2'd2;
    localparam logic [JW-1:0] JOB_Y     = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_MUL,
        S_DIV,
        S_STORE,
        S_OUT
    } t_state;

    t_state          r_state, n_state;
    logic [JW-1:0]   r_job, n_job;
    t_pkt            r_pkt, n_pkt;
    logic [MW-1:0]   r_mag_num, n_mag_num;
    logic [MW-1:0]   r_mag_den, n_mag_den;
    logic            r_zero, n_zero;
    logic            r_sat, n_sat;
    logic [MW-1:0]   r_rem, n_rem;
    logic [QW-1:0]   r_low, n_low;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic [QW-1:0]   r_res [NJOB];
    logic [QW-1:0]   n_res [NJOB];
    logic            r_out_valid, n_out_valid;
    logic            r_status, n_status;
    logic [4:0]      r_finger_count, n_finger_count;
    logic            r_touch_valid, n_touch_valid;
    logic [7:0]      r_pressure, n_pressure;
    logic [3:0]      r_tool_width, n_tool_width;
    logic [10:0]     r_x_pos, n_x_pos;
    logic [9:0]      r_y_pos, n_y_pos;
    logic [1:0]      r_tool_class, n_tool_class;

    logic [MW-1:0]    num, den, abs_num, abs_den;
    logic [SW-1:0]    span;
    logic [MW+SW-1:0] prod;
    logic [MW:0]      trial;
    logic             qbit;
    logic             has_touch;

    always_comb begin
        case (r_job)
            JOB_FORCE: span = SW'(FORCE_SPAN);
            JOB_SIZE:  span = SW'(WIDTH_SPAN);
            JOB_X:     span = SW'(X_SPAN);
            JOB_Y:     span = SW'(Y_SPAN);
            default:   span = SW'(FORCE_SPAN);
        endcase
    end

    always_comb begin
        case (r_job)
            JOB_FORCE: begin
                num = {r_pkt.raw_force[15], r_pkt.raw_force};
                den = {1'b0, i_cfg.force_range};
            end
            JOB_SIZE: begin
                num = {r_pkt.raw_size[15], r_pkt.raw_size};
                den = {1'b0, i_cfg.size_range};
            end
            JOB_X: begin
                num = {r_pkt.raw_x[15], r_pkt.raw_x} - {i_cfg.x_min[15], i_cfg.x_min};
                den = {i_cfg.x_max[15], i_cfg.x_max} - {i_cfg.x_min[15], i_cfg.x_min};
            end
            JOB_Y: begin
                num = {i_cfg.y_max[15], i_cfg.y_max} - {r_pkt.raw_y[15], r_pkt.raw_y};
                den = {i_cfg.y_max[15], i_cfg.y_max} - {i_cfg.y_min[15], i_cfg.y_min};
            end
            default: begin
                num = '0;
                den = '0;
            end
        endcase
        abs_num = num[MW-1] ? (~num + 1'b1) : num;
        abs_den = den[MW-1] ? (~den + 1'b1) : den;
    end

    assign prod      = (MW+SW)'(r_mag_num) * (MW+SW)'(span);
    assign trial     = {r_rem, r_low[QW-1]};
    assign qbit      = (trial >= {1'b0, r_mag_den});
    assign has_touch = !r_pkt.bad && (r_pkt.fingers != '0);

    always_comb begin
        n_state        = r_state;
        n_job          = r_job;
        n_pkt          = r_pkt;
        n_mag_num      = r_mag_num;
        n_mag_den      = r_mag_den;
        n_zero         = r_zero;
        n_sat          = r_sat;
        n_rem          = r_rem;
        n_low          = r_low;
        n_cnt          = r_cnt;
        n_res          = r_res;
        n_out_valid    = r_out_valid && i_out_stall;
        n_status       = r_status;
        n_finger_count = r_finger_count;
        n_touch_valid  = r_touch_valid;
        n_pressure     = r_pressure;
        n_tool_width   = r_tool_width;
        n_x_pos        = r_x_pos;
        n_y_pos        = r_y_pos;
        n_tool_class   = r_tool_class;
        o_pop          = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop = 1'b1;
                    n_pkt = i_head;
                    n_job = JOB_FORCE;
                    if (i_head.bad || (i_head.fingers == '0)) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_LOAD;
                    end
                end
            end
            S_LOAD: begin
                n_mag_num = abs_num;
                n_mag_den = abs_den;
                n_zero    = (den == '0) || (num == '0) || (num[MW-1] != den[MW-1]);
                n_sat     = (abs_num >= abs_den);
                n_state   = S_MUL;
            end
            S_MUL: begin
                // quotient is below span once |num| < |den|, so the top part starts below den
                n_rem   = prod[QW +: MW];
                n_low   = prod[QW-1:0];
                n_cnt   = CNTW'(QW - 1);
                n_state = (r_zero || r_sat) ? S_STORE : S_DIV;
            end
            S_DIV: begin
                n_rem = qbit ? MW'(trial - {1'b0, r_mag_den}) : trial[MW-1:0];
                n_low = {r_low[QW-2:0], qbit};
                if (r_cnt == '0) begin
                    n_state = S_STORE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_STORE: begin
                if (r_zero) begin
                    n_res[r_job] = '0;
                end else if (r_sat) begin
                    n_res[r_job] = QW'(span - 1'b1);
                end else begin
                    n_res[r_job] = r_low;
                end
                if (r_job == JW'(NJOB - 1)) begin
                    n_state = S_OUT;
                end else begin
                    n_job   = r_job + 1'b1;
                    n_state = S_LOAD;
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid    = 1'b1;
                    n_status       = r_pkt.bad;
                    n_finger_count = r_pkt.bad ? 5'd0 : 5'(r_pkt.fingers);
                    n_touch_valid  = has_touch;
                    n_pressure     = has_touch ? 8'(r_res[JOB_FORCE]) : 8'd0;
                    n_tool_width   = has_touch ? 4'(r_res[JOB_SIZE]) : 4'd0;
                    n_x_pos        = has_touch ? 11'(r_res[JOB_X]) : 11'd0;
                    n_y_pos        = has_touch ? 10'(r_res[JOB_Y]) : 10'd0;
                    if (has_touch && !r_pkt.raw_force[15] && (r_pkt.raw_force != '0)) begin
                        n_tool_class = (r_pkt.fingers >= FW'(3)) ? 2'd3 : 2'(r_pkt.fingers);
                    end else begin
                        n_tool_class = 2'd0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_job       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_job       <= n_job;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
        r_pkt          <= n_pkt;
        r_mag_num      <= n_mag_num;
        r_mag_den      <= n_mag_den;
        r_zero         <= n_zero;
        r_sat          <= n_sat;
        r_rem          <= n_rem;
        r_low          <= n_low;
        r_res          <= n_res;
        r_status       <= n_status;
        r_finger_count <= n_finger_count;
        r_touch_valid  <= n_touch_valid;
        r_pressure     <= n_pressure;
        r_tool_width   <= n_tool_width;
        r_x_pos        <= n_x_pos;
        r_y_pos        <= n_y_pos;
        r_tool_class   <= n_tool_class;
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_finger_count = r_finger_count;
    assign o_touch_valid  = r_touch_valid;
    assign o_pressure     = r_pressure;
    assign o_tool_width   = r_tool_width;
    assign o_x_pos        = r_x_pos;
    assign o_y_pos        = r_y_pos;
    assign o_tool_class   = r_tool_class;

endmodule

// File: hw/rtl/touchpad_packet_scaler.sv
// touchpad_packet_scaler: top level; configuration registers, parser, queue and scaling back end.
// Depends on tpps_pkg, tpps_front, tpps_fifo and tpps_back.
`timescale 1ns / 1ps

// Report bytes are taken one per cycle. On the last byte of a report the parser pushes a
// summary into a two-entry queue; the back end scales force, size, x and y one after the
// other through a single restoring divider (11 quotient bits a value, one bit a cycle).
// A value that clamps or comes out zero skips the divide, and a bad or empty report skips
// all four scalings. Input stalls only while the queue holds two reports, which a stream
// of full-length reports does not reach unless the output stalls. The first report after
// reset gives no item.
module touchpad_packet_scaler (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [tpps_pkg::CIW-1:0] i_cfg_idx,
    input  logic [tpps_pkg::CW-1:0]  i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [7:0]               i_data_byte,
    input  logic                     i_last_byte,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic                     o_status,
    output logic [4:0]               o_finger_count,
    output logic                     o_touch_valid,
    output logic [7:0]               o_pressure,
    output logic [3:0]               o_tool_width,
    output logic [10:0]              o_x_pos,
    output logic [9:0]               o_y_pos,
    output logic [1:0]               o_tool_class
);
    import tpps_pkg::*;

    t_cfg    r_cfg, n_cfg;
    t_pkt    w_push_pkt, w_head;
    t_q_stat w_q_stat;
    logic    w_take, w_push, w_pop;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_X_MIN:       n_cfg.x_min       = i_cfg_data;
                CFG_X_MAX:       n_cfg.x_max       = i_cfg_data;
                CFG_Y_MIN:       n_cfg.y_min       = i_cfg_data;
                CFG_Y_MAX:       n_cfg.y_max       = i_cfg_data;
                CFG_FORCE_RANGE: n_cfg.force_range = i_cfg_data;
                CFG_SIZE_RANGE:  n_cfg.size_range  = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_min       <= X_MIN_RST;
            r_cfg.x_max       <= X_MAX_RST;
            r_cfg.y_min       <= Y_MIN_RST;
            r_cfg.y_max       <= Y_MAX_RST;
            r_cfg.force_range <= FORCE_RANGE_RST;
            r_cfg.size_range  <= SIZE_RANGE_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_in_stall = w_q_stat.full;
    assign w_take     = i_in_valid && !w_q_stat.full;

    tpps_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (w_take),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_push      (w_push),
        .o_pkt       (w_push_pkt)
    );

    tpps_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pkt   (w_push_pkt),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    tpps_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_q_stat       (w_q_stat),
        .i_head         (w_head),
        .o_pop          (w_pop),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_status       (o_status),
        .o_finger_count (o_finger_count),
        .o_touch_valid  (o_touch_valid),
        .o_pressure     (o_pressure),
        .o_tool_width   (o_tool_width),
        .o_x_pos        (o_x_pos),
        .o_y_pos        (o_y_pos),
        .o_tool_class   (o_tool_class)
    );

`ifndef SYNTHESIS
    a_bad_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status |-> o_finger_count == 5'd0 && !o_touch_valid &&
            o_pressure == 8'd0 && o_tool_width == 4'd0 && o_x_pos == 11'd0 &&
            o_y_pos == 10'd0 && o_tool_class == 2'd0)
        else $error("bad length item carries nonzero fields");

    a_no_touch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_touch_valid |-> o_tool_class == 2'd0 && o_pressure == 8'd0 &&
            o_x_pos == 11'd0 && o_y_pos == 10'd0)
        else $error("item without touch carries position or class");

    a_touch_fingers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_touch_valid |-> o_finger_count != 5'd0 && !o_status)
        else $error("touch reported without finger records");
`endif

endmodule
